// ----- rtl/core/ctqw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing task queue package
// Operation and status codes, request and result structures.
// ----------------------------------------------------------------------------
package ctqw_pkg;

	localparam logic [2:0] OP_SUBMIT_PLAIN = 3'd0;
	localparam logic [2:0] OP_SUBMIT_KEYED = 3'd1;
	localparam logic [2:0] OP_TAKE        = 3'd2;
	localparam logic [2:0] OP_DONE        = 3'd3;
	localparam logic [2:0] OP_TICK        = 3'd4;
	localparam logic [2:0] OP_STOP        = 3'd5;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_COALESCED  = 4'd1;
	localparam logic [3:0] ST_DROPPED    = 4'd2;
	localparam logic [3:0] ST_INVALID    = 4'd3;
	localparam logic [3:0] ST_STOPPING   = 4'd4;
	localparam logic [3:0] ST_FULL       = 4'd5;
	localparam logic [3:0] ST_DISPATCHED = 4'd6;
	localparam logic [3:0] ST_EMPTY      = 4'd7;
	localparam logic [3:0] ST_BUSY       = 4'd8;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] task_handle;
		logic [15:0] state_key;
		logic [15:0] timeout_ticks;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] out_handle;
		logic [15:0] out_timeout;
		logic        from_keyed;
		logic        timeout_event;
		logic        busy_res;
	} res_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

endpackage

// ----- rtl/core/coalescing_task_queue_watchdog_core.sv -----
`timescale 1ns / 1ps
// A request is captured in the idle state and executed in the execute state, which registers its result.
// The controller takes no new request while busy; busy is high in the execute state.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset clears counts, watchdog state and stop; the limit resets to 16.
// ----------------------------------------------------------------------------
// Coalescing task queue with watchdog
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module coalescing_task_queue_watchdog_core #(
	parameter int PLAIN_DEPTH = 16,
	parameter int KEYED_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ctqw_pkg::req_t req,
	output logic           done,
	output ctqw_pkg::res_t res,
	input  logic           cfg_we,
	input  logic [4:0]     cfg_wdata
);

	ctqw_pkg::cmd_t cmd;

	ctqw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ctqw_dp #(
		.PLAIN_DEPTH (PLAIN_DEPTH),
		.KEYED_DEPTH (KEYED_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res),
		.res_valid (done)
	);

endmodule

// ----- rtl/core/ctqw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing task queue controller
// Sequences capture of a request and its execution in the datapath.
// ----------------------------------------------------------------------------
module ctqw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output ctqw_pkg::cmd_t cmd
);

	ctqw_pkg::state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctqw_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				ctqw_pkg::S_IDLE: if (start) state_q <= ctqw_pkg::S_EXEC;
				ctqw_pkg::S_EXEC: state_q <= ctqw_pkg::S_IDLE;
				default:          state_q <= ctqw_pkg::S_IDLE;
			endcase
		end
	end

	assign busy        = (state_q == ctqw_pkg::S_EXEC);
	assign cmd.capture = (state_q == ctqw_pkg::S_IDLE) && start;
	assign cmd.execute = (state_q == ctqw_pkg::S_EXEC);

endmodule

// ----- rtl/core/ctqw_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coalescing task queue datapath
// Plain FIFO memory, ordered keyed table, watchdog and result register.
// ----------------------------------------------------------------------------
module ctqw_dp #(
	parameter int PLAIN_DEPTH = 16,
	parameter int KEYED_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ctqw_pkg::cmd_t cmd,
	input  ctqw_pkg::req_t req,
	input  logic           cfg_we,
	input  logic [4:0]     cfg_wdata,
	output ctqw_pkg::res_t res,
	output logic           res_valid
);

	localparam int PW = (PLAIN_DEPTH > 1) ? $clog2(PLAIN_DEPTH) : 1;
	localparam int PCW = $clog2(PLAIN_DEPTH + 1);
	localparam int SW = PCW + 1;
	localparam int KW = (KEYED_DEPTH > 1) ? $clog2(KEYED_DEPTH) : 1;
	localparam int KCW = $clog2(KEYED_DEPTH + 1);
	localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

	ctqw_pkg::req_t req_q;
	logic [4:0]     limit_q;
	logic [31:0]    plain_mem [PLAIN_DEPTH];
	logic [31:0]    plain_rd_q;
	logic [PW-1:0]  head_q;
	logic [PCW-1:0] pcount_q;
	logic [15:0]    kkey_q [KEYED_DEPTH];
	logic [15:0]    khnd_q [KEYED_DEPTH];
	logic [15:0]    ktmo_q [KEYED_DEPTH];
	logic [KCW-1:0] kcount_q;
	logic           running_q;
	logic [16:0]    elapsed_q;
	logic [15:0]    climit_q;
	logic           expired_q;
	logic           fired_q;
	logic           stop_q;
	ctqw_pkg::res_t res_q;
	logic           res_valid_q;

	logic [KCW-1:0] lim_use;
	logic [KEYED_DEPTH-1:0] hit;
	logic           found;
	logic [KW-1:0]  hit_idx;
	logic [SW-1:0]  tail_sum;
	logic [PW-1:0]  tail;
	logic [PW-1:0]  head_nxt;
	logic [16:0]    elapsed_inc;

	always_comb begin
		if (limit_q == 5'd0) lim_use = KCW'(1);
		else if ({27'd0, limit_q} > KEYED_DEPTH) lim_use = KCW'(KEYED_DEPTH);
		else lim_use = KCW'(limit_q);
	end

	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < KEYED_DEPTH; i++) begin
			hit[i] = (KCW'(i) < kcount_q) && (kkey_q[i] == req_q.state_key);
		end
		for (int i = KEYED_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found   = 1'b1;
				hit_idx = KW'(i);
			end
		end
	end

	// The FIFO pointers wrap by compare, so any depth works.
	assign tail_sum = SW'(head_q) + SW'(pcount_q);
	assign tail = (tail_sum >= SW'(PLAIN_DEPTH)) ? PW'(tail_sum - SW'(PLAIN_DEPTH))
		: PW'(tail_sum);
	assign head_nxt = (head_q == PW'(PLAIN_DEPTH - 1)) ? '0 : head_q + PW'(1);
	assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 17'd1 : elapsed_q;

	// The FIFO head is read into a register while the request is captured.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= req;
			plain_rd_q <= plain_mem[head_q];
		end
		if (cmd.execute && req_q.op == ctqw_pkg::OP_SUBMIT_PLAIN
			&& req_q.task_handle != 16'd0 && req_q.timeout_ticks != 16'd0
			&& !stop_q && pcount_q < PCW'(PLAIN_DEPTH)) begin
			plain_mem[tail] <= {req_q.task_handle, req_q.timeout_ticks};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= 5'd16;
			head_q      <= '0;
			pcount_q    <= '0;
			kcount_q    <= '0;
			running_q   <= 1'b0;
			elapsed_q   <= '0;
			climit_q    <= '0;
			expired_q   <= 1'b0;
			fired_q     <= 1'b0;
			stop_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			res_valid_q <= cmd.execute;
			if (cmd.execute) begin
				automatic ctqw_pkg::res_t r = '0;
				automatic logic p_nz = (pcount_q != '0);
				automatic logic k_nz = (kcount_q != '0);
				automatic logic run = running_q;
				r.status = ctqw_pkg::ST_OK;
				case (req_q.op)
					ctqw_pkg::OP_SUBMIT_PLAIN: begin
						if (req_q.task_handle == 16'd0 || req_q.timeout_ticks == 16'd0)
							r.status = ctqw_pkg::ST_INVALID;
						else if (stop_q) r.status = ctqw_pkg::ST_STOPPING;
						else if (pcount_q >= PCW'(PLAIN_DEPTH)) r.status = ctqw_pkg::ST_FULL;
						else begin
							pcount_q <= pcount_q + PCW'(1);
							p_nz = 1'b1;
						end
					end
					ctqw_pkg::OP_SUBMIT_KEYED: begin
						if (req_q.task_handle == 16'd0 || req_q.state_key == 16'd0
							|| req_q.timeout_ticks == 16'd0)
							r.status = ctqw_pkg::ST_INVALID;
						else if (stop_q) r.status = ctqw_pkg::ST_STOPPING;
						else if (found) begin
							r.status        = ctqw_pkg::ST_COALESCED;
							khnd_q[hit_idx] <= req_q.task_handle;
							ktmo_q[hit_idx] <= req_q.timeout_ticks;
						end else if (kcount_q >= lim_use) begin
							// Evict the oldest and append at the old end position.
							r.status = ctqw_pkg::ST_DROPPED;
							for (int i = 0; i < KEYED_DEPTH - 1; i++) begin
								if (KCW'(i + 1) < kcount_q) begin
									kkey_q[i] <= kkey_q[i+1];
									khnd_q[i] <= khnd_q[i+1];
									ktmo_q[i] <= ktmo_q[i+1];
								end
							end
							kkey_q[KW'(kcount_q - KCW'(1))] <= req_q.state_key;
							khnd_q[KW'(kcount_q - KCW'(1))] <= req_q.task_handle;
							ktmo_q[KW'(kcount_q - KCW'(1))] <= req_q.timeout_ticks;
						end else begin
							kkey_q[KW'(kcount_q)] <= req_q.state_key;
							khnd_q[KW'(kcount_q)] <= req_q.task_handle;
							ktmo_q[KW'(kcount_q)] <= req_q.timeout_ticks;
							kcount_q <= kcount_q + KCW'(1);
							k_nz = 1'b1;
						end
					end
					ctqw_pkg::OP_TAKE: begin
						if (running_q) r.status = ctqw_pkg::ST_BUSY;
						else if (p_nz) begin
							r.status      = ctqw_pkg::ST_DISPATCHED;
							r.out_handle  = plain_rd_q[31:16];
							r.out_timeout = plain_rd_q[15:0];
							head_q   <= head_nxt;
							pcount_q <= pcount_q - PCW'(1);
							p_nz      = (pcount_q != PCW'(1));
							run       = 1'b1;
							running_q <= 1'b1;
							elapsed_q <= '0;
							climit_q  <= plain_rd_q[15:0];
							expired_q <= 1'b0;
						end else if (k_nz) begin
							r.status      = ctqw_pkg::ST_DISPATCHED;
							r.out_handle  = khnd_q[0];
							r.out_timeout = ktmo_q[0];
							r.from_keyed  = 1'b1;
							for (int i = 0; i < KEYED_DEPTH - 1; i++) begin
								kkey_q[i] <= kkey_q[i+1];
								khnd_q[i] <= khnd_q[i+1];
								ktmo_q[i] <= ktmo_q[i+1];
							end
							kcount_q <= kcount_q - KCW'(1);
							k_nz      = (kcount_q != KCW'(1));
							run       = 1'b1;
							running_q <= 1'b1;
							elapsed_q <= '0;
							climit_q  <= ktmo_q[0];
							expired_q <= 1'b0;
						end else r.status = ctqw_pkg::ST_EMPTY;
					end
					ctqw_pkg::OP_DONE: begin
						if (!running_q) r.status = ctqw_pkg::ST_INVALID;
						else begin
							run       = 1'b0;
							running_q <= 1'b0;
							elapsed_q <= '0;
							climit_q  <= '0;
						end
					end
					ctqw_pkg::OP_TICK: begin
						if (running_q) begin
							elapsed_q <= elapsed_inc;
							if (!stop_q && !fired_q && !expired_q
								&& elapsed_inc > {1'b0, climit_q}) begin
								expired_q       <= 1'b1;
								fired_q         <= 1'b1;
								r.timeout_event = 1'b1;
							end
						end
					end
					ctqw_pkg::OP_STOP: begin
						stop_q   <= 1'b1;
						pcount_q <= '0;
						head_q   <= '0;
						kcount_q <= '0;
						p_nz = 1'b0;
						k_nz = 1'b0;
					end
					default: r.status = ctqw_pkg::ST_INVALID;
				endcase
				r.busy_res = run || p_nz || k_nz;
				res_q <= r;
			end
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule
